/* src/sss_pkg.sv */
// shared types, codes and constants of the spi sram word access sequencer
package sss_pkg;

  localparam int ACTION_W  = 3;
  localparam int ADDR_W    = 18;
  localparam int DATA_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int BADDR_W   = 24;
  localparam int COUNT_W   = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int CHIP_SELECT_BIT_DEF = 18;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WORD_WR = 3'd0,
    ACT_WORD_RD = 3'd1,
    ACT_LONG_WR = 3'd2,
    ACT_LONG_RD = 3'd3,
    ACT_RX_BYTE = 3'd4
  } sss_action_t;

  localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_READ   = 8'h03;
  localparam logic [BYTE_W-1:0] DUMMY_BYTE = 8'h00;

  localparam logic [COUNT_W-1:0] FRAMES_WORD_WR = 5'd10;
  localparam logic [COUNT_W-1:0] FRAMES_WORD_RD = 5'd12;
  localparam logic [COUNT_W-1:0] FRAMES_LONG_WR = 5'd20;
  localparam logic [COUNT_W-1:0] FRAMES_LONG_RD = 5'd24;

  localparam logic [2:0] STEP_LAST_WR = 3'd4;
  localparam logic [2:0] STEP_LAST_RD = 3'd5;
  localparam logic [2:0] STEP_RX_SLOT = 3'd5;

  typedef struct packed {
    logic              is_result;
    logic              is_read;
    logic              is_long;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
  } sss_job_t;

  typedef struct packed {
    logic     push;
    sss_job_t job;
  } sss_push_t;

endpackage

/* src/sss_if.sv */
// request and result channel interfaces
interface sss_in_if;
  logic                         valid;
  logic                         ready;
  logic [sss_pkg::ACTION_W-1:0] action;
  logic [sss_pkg::ADDR_W-1:0]   address;
  logic [sss_pkg::DATA_W-1:0]   write_data;
  logic [sss_pkg::BYTE_W-1:0]   rx_byte;
  modport source(output valid, action, address, write_data, rx_byte, input ready);
  modport sink(input valid, action, address, write_data, rx_byte, output ready);
endinterface

interface sss_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       chip;
  logic [sss_pkg::BYTE_W-1:0] tx_byte;
  logic                       release_select;
  logic [sss_pkg::DATA_W-1:0] read_data;
  logic                       last;
  modport source(output valid, kind, chip, tx_byte, release_select, read_data, last,
                 input ready);
  modport sink(input valid, kind, chip, tx_byte, release_select, read_data, last,
               output ready);
endinterface

/* src/sss_front.sv */
// front end: accepts requests, tracks outstanding frames, assembles read data
module sss_front (
  input  logic               clk,
  input  logic               rst_n,
  sss_in_if.sink             in_req,
  input  logic               q_full,
  output sss_pkg::sss_push_t q_push
);
  import sss_pkg::*;

  logic [1:0]         pending_op_r, pending_op_nxt;
  logic [COUNT_W-1:0] outstanding_r, outstanding_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [DATA_W-1:0]  assembly_r, assembly_nxt;
  logic               accept;
  logic [DATA_W-1:0]  rx_shifted;
  logic [DATA_W-1:0]  rx_merged;

  assign in_req.ready = !q_full;
  assign accept = in_req.valid && !q_full;

  always_comb begin
    unique case (idx_r)
      2'd0: rx_shifted = {24'b0, in_req.rx_byte};
      2'd1: rx_shifted = {16'b0, in_req.rx_byte, 8'b0};
      2'd2: rx_shifted = {8'b0, in_req.rx_byte, 16'b0};
      default: rx_shifted = {in_req.rx_byte, 24'b0};
    endcase
  end

  assign rx_merged = (pending_op_r[0] && pos_r == STEP_RX_SLOT) ?
                     (assembly_r | rx_shifted) : assembly_r;

  always_comb begin
    pending_op_nxt  = pending_op_r;
    outstanding_nxt = outstanding_r;
    pos_nxt         = pos_r;
    idx_nxt         = idx_r;
    assembly_nxt    = assembly_r;
    q_push.push          = 1'b0;
    q_push.job.is_result = 1'b0;
    q_push.job.is_read   = in_req.action[0];
    q_push.job.is_long   = in_req.action[1];
    q_push.job.address   = in_req.address;
    q_push.job.data      = in_req.write_data;
    if (accept) begin
      priority if (in_req.action == ACT_RX_BYTE) begin
        if (outstanding_r != '0) begin
          assembly_nxt    = rx_merged;
          outstanding_nxt = outstanding_r - 1'b1;
          if (pos_r == STEP_RX_SLOT) begin
            pos_nxt = '0;
            idx_nxt = idx_r + 1'b1;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
          if (outstanding_r == 5'd1 && pending_op_r[0]) begin
            q_push.push          = 1'b1;
            q_push.job.is_result = 1'b1;
            q_push.job.data      = pending_op_r[1] ? rx_merged : {16'b0, rx_merged[15:0]};
          end
        end
      end else if (in_req.action[2] == 1'b0) begin
        if (outstanding_r == '0) begin
          pending_op_nxt = in_req.action[1:0];
          unique case (in_req.action)
            ACT_WORD_WR: outstanding_nxt = FRAMES_WORD_WR;
            ACT_WORD_RD: outstanding_nxt = FRAMES_WORD_RD;
            ACT_LONG_WR: outstanding_nxt = FRAMES_LONG_WR;
            default: outstanding_nxt = FRAMES_LONG_RD;
          endcase
          pos_nxt      = '0;
          idx_nxt      = '0;
          assembly_nxt = '0;
          q_push.push  = 1'b1;
        end
      end else begin
        pending_op_nxt = pending_op_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_op_r  <= '0;
      outstanding_r <= '0;
      pos_r         <= '0;
      idx_r         <= '0;
      assembly_r    <= '0;
    end else begin
      pending_op_r  <= pending_op_nxt;
      outstanding_r <= outstanding_nxt;
      pos_r         <= pos_nxt;
      idx_r         <= idx_nxt;
      assembly_r    <= assembly_nxt;
    end
  end

endmodule

/* src/sss_queue.sv */
// short job queue between front end and frame generator
module sss_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  sss_pkg::sss_push_t q_push,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output sss_pkg::sss_job_t  head
);
  import sss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sss_job_t           slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_push.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots_r[wr_ptr_r] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/sss_back.sv */
// back end: expands jobs into spi byte frames and read results
module sss_back #(
  parameter int CHIP_SELECT_BIT = sss_pkg::CHIP_SELECT_BIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  sss_pkg::sss_job_t head,
  output logic              pop,
  sss_out_if.source         out_res
);
  import sss_pkg::*;

  logic [1:0]         byte_r, byte_nxt;
  logic [2:0]         step_r, step_nxt;
  logic               valid_r;
  logic               kind_r, chip_r, release_r, last_r;
  logic [BYTE_W-1:0]  tx_r;
  logic [DATA_W-1:0]  data_r;
  logic               load;
  logic [BADDR_W-1:0] base_addr;
  logic [BADDR_W-1:0] byte_addr;
  logic [2:0]         step_last;
  logic [1:0]         byte_last;
  logic               step_end;
  logic               job_end;
  logic [BYTE_W-1:0]  wr_byte;
  logic [BYTE_W-1:0]  tx_sel;

  assign load = head_valid && (!valid_r || out_res.ready);

  assign base_addr = head.is_long ? {4'b0, head.address, 2'b0} : {5'b0, head.address, 1'b0};
  assign byte_addr = base_addr + {22'b0, byte_r};
  assign step_last = head.is_read ? STEP_LAST_RD : STEP_LAST_WR;
  assign byte_last = head.is_long ? 2'd3 : 2'd1;
  assign step_end  = (step_r == step_last);
  assign job_end   = head.is_result || (step_end && byte_r == byte_last);
  assign pop       = load && job_end;

  always_comb begin
    unique case (byte_r)
      2'd0: wr_byte = head.data[7:0];
      2'd1: wr_byte = head.data[15:8];
      2'd2: wr_byte = head.data[23:16];
      default: wr_byte = head.data[31:24];
    endcase
  end

  always_comb begin
    unique case (step_r)
      3'd0: tx_sel = head.is_read ? CMD_READ : CMD_WRITE;
      3'd1: tx_sel = byte_addr[23:16];
      3'd2: tx_sel = byte_addr[15:8];
      3'd3: tx_sel = byte_addr[7:0];
      3'd4: tx_sel = head.is_read ? DUMMY_BYTE : wr_byte;
      default: tx_sel = DUMMY_BYTE;
    endcase
  end

  always_comb begin
    byte_nxt = byte_r;
    step_nxt = step_r;
    if (load && !head.is_result) begin
      if (job_end) begin
        byte_nxt = '0;
        step_nxt = '0;
      end else if (step_end) begin
        byte_nxt = byte_r + 1'b1;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      byte_r  <= '0;
      step_r  <= '0;
    end else begin
      byte_r <= byte_nxt;
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_res.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.is_result) begin
        kind_r    <= 1'b1;
        chip_r    <= 1'b0;
        tx_r      <= '0;
        release_r <= 1'b0;
        data_r    <= head.data;
        last_r    <= 1'b1;
      end else begin
        kind_r    <= 1'b0;
        chip_r    <= byte_addr[CHIP_SELECT_BIT];
        tx_r      <= tx_sel;
        release_r <= step_end;
        data_r    <= '0;
        last_r    <= job_end;
      end
    end
  end

  assign out_res.valid          = valid_r;
  assign out_res.kind           = kind_r;
  assign out_res.chip           = chip_r;
  assign out_res.tx_byte        = tx_r;
  assign out_res.release_select = release_r;
  assign out_res.read_data      = data_r;
  assign out_res.last           = last_r;

endmodule

/* src/spi_sram_word_access_sequencer.sv */
// top level of the spi sram word access sequencer
// usage:
//   in_req carries requests: word/long write or read, or a byte received on the bus.
//   a request is accepted when valid and ready are both high; ready is low only
//   while the four-entry job queue is full.
//   out_res carries one result per spi byte frame (kind 0) and one per completed
//   read (kind 1); last marks the final frame of a request and every read result.
//   a write expands into 10 (word) or 20 (long) frames, a read into 12 or 24.
//   the first frame of a request passes through the job queue and the output
//   register, behind any jobs still queued; the frame generator then emits one
//   frame per cycle while the receiver is ready, while requests and received
//   bytes are taken one per cycle as long as the queue has room.
//   a read result passes through the queue and the output register after the
//   received byte that completes it, behind every frame queued ahead of it.
//   requests arriving while frames are outstanding are dropped without result.
//   reset clears the outstanding count, pending request and queue at once.
//   when the receiver stalls, the output register holds its result, the queue
//   fills, and only then is ready dropped.
module spi_sram_word_access_sequencer #(
  parameter int CHIP_SELECT_BIT = sss_pkg::CHIP_SELECT_BIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sss_in_if.sink     in_req,
  sss_out_if.source  out_res
);
  import sss_pkg::*;

  sss_push_t q_push;
  sss_job_t  head;
  logic      q_full;
  logic      head_valid;
  logic      pop;

  sss_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_full (q_full),
    .q_push (q_push)
  );

  sss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  sss_back #(
    .CHIP_SELECT_BIT (CHIP_SELECT_BIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_res    (out_res)
  );

endmodule

/* tb/tb_spi_sram_word_access_sequencer.sv */
// testbench for the spi sram word access sequencer: checks spi frames and read data
`timescale 1ns / 1ps

module tb_spi_sram_word_access_sequencer;
  import sss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int NOISE_PCT = 6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic              kind;
    logic              chip;
    logic [BYTE_W-1:0] tx_byte;
    logic              release_select;
    logic [DATA_W-1:0] read_data;
    logic              last;
  } sram_frame_t;

  class sram_frame_scoreboard;
    logic [1:0]         pending_op;
    logic [COUNT_W-1:0] frames_open;
    logic [COUNT_W-1:0] frames_back;
    logic [DATA_W-1:0]  read_word;
    sram_frame_t        expected_frames[$];
    int                 effective_items;
    int                 failures;

    function new();
      pending_op = '0;
      frames_open = '0;
      frames_back = '0;
      read_word = '0;
      effective_items = 0;
      failures = 0;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] wdata, logic [BYTE_W-1:0] rx);
      logic               rd;
      logic               lng;
      int                 nbytes;
      int                 per;
      int                 total;
      int                 k;
      logic [BADDR_W-1:0] base;
      logic [BADDR_W-1:0] baddr;
      logic [BYTE_W-1:0]  seq[6];
      sram_frame_t        f;
      if (act <= ACT_LONG_RD) begin
        if (frames_open != '0) return;
        rd = (act == ACT_WORD_RD) || (act == ACT_LONG_RD);
        lng = (act == ACT_LONG_WR) || (act == ACT_LONG_RD);
        nbytes = lng ? 4 : 2;
        per = rd ? 6 : 5;
        total = nbytes * per;
        base = lng ? {4'b0, addr, 2'b00} : {5'b0, addr, 1'b0};
        pending_op = act[1:0];
        frames_open = total[COUNT_W-1:0];
        frames_back = '0;
        read_word = '0;
        effective_items++;
        k = 0;
        for (int i = 0; i < nbytes; i++) begin
          baddr = base + BADDR_W'(i);
          seq[0] = rd ? CMD_READ : CMD_WRITE;
          seq[1] = baddr[23:16];
          seq[2] = baddr[15:8];
          seq[3] = baddr[7:0];
          seq[4] = rd ? DUMMY_BYTE : wdata[8*i +: 8];
          seq[5] = DUMMY_BYTE;
          for (int j = 0; j < per; j++) begin
            f.kind = 1'b0;
            f.chip = baddr[CHIP_SELECT_BIT_DEF];
            f.tx_byte = seq[j];
            f.release_select = (j == per - 1);
            f.read_data = '0;
            f.last = (k == total - 1);
            expected_frames.push_back(f);
            k++;
          end
        end
      end else if (act == ACT_RX_BYTE) begin
        if (frames_open == '0) return;
        effective_items++;
        if (pending_op[0] && (frames_back % 6 == 5) && (frames_back / 6 < 4))
          read_word |= DATA_W'(rx) << (8 * (frames_back / 6));
        frames_back++;
        frames_open--;
        if (frames_open == '0 && pending_op[0]) begin
          f = '0;
          f.kind = 1'b1;
          f.last = 1'b1;
          f.read_data = pending_op[1] ? read_word : {16'b0, read_word[15:0]};
          expected_frames.push_back(f);
        end
      end
    endfunction

    function void report(string why, sram_frame_t want, sram_frame_t got);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%s: expected kind=%0d chip=%0d tx=%02h rel=%0d data=%08h last=%0d",
                 why, want.kind, want.chip, want.tx_byte, want.release_select,
                 want.read_data, want.last);
        $display("  got kind=%0d chip=%0d tx=%02h rel=%0d data=%08h last=%0d",
                 got.kind, got.chip, got.tx_byte, got.release_select,
                 got.read_data, got.last);
      end
    endfunction

    function void check_frame(sram_frame_t got);
      sram_frame_t want;
      if (expected_frames.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_frames.pop_front();
      if (got.kind !== want.kind || got.chip !== want.chip || got.tx_byte !== want.tx_byte ||
          got.release_select !== want.release_select || got.read_data !== want.read_data ||
          got.last !== want.last)
        report("mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 37;
  int   recv_idle_pct = 68;
  int   stall_cycles = 0;
  sram_frame_scoreboard scoreboard = new();

  sss_in_if  in_req();
  sss_out_if out_res();

  spi_sram_word_access_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_res.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready)
      scoreboard.check_frame({out_res.kind, out_res.chip, out_res.tx_byte,
                              out_res.release_select, out_res.read_data, out_res.last});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_spi_sram_word_access_sequencer: done, errors");
        $finish;
      end
    end
  end

  task automatic send_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] wdata, logic [BYTE_W-1:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid = 1'b0;
      @(negedge clk);
    end
    in_req.valid = 1'b1;
    in_req.action = act;
    in_req.address = addr;
    in_req.write_data = wdata;
    in_req.rx_byte = rx;
    do @(posedge clk); while (!in_req.ready);
    scoreboard.note_request(act, addr, wdata, rx);
    @(negedge clk);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(ACTION_W'($urandom_range(int'(ACT_LONG_RD))), ADDR_W'($urandom),
                   $urandom, BYTE_W'($urandom));
      1: send_item(ACTION_W'($urandom_range(int'(ACT_UNUSED_HI), int'(ACT_UNUSED_LO))),
                   ADDR_W'($urandom), $urandom, BYTE_W'($urandom));
      default: send_item(ACT_RX_BYTE, ADDR_W'($urandom), $urandom, BYTE_W'($urandom));
    endcase
  endtask

  task automatic run_transfer(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] wdata, int noise_pct);
    int nframes;
    nframes = (act[1] ? 4 : 2) * (act[0] ? 6 : 5);
    send_item(act, addr, wdata, BYTE_W'($urandom));
    for (int i = 0; i < nframes; i++) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      send_item(ACT_RX_BYTE, ADDR_W'($urandom), $urandom, BYTE_W'($urandom));
    end
  endtask

  task automatic random_transfer();
    logic [ACTION_W-1:0] act;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    act = ACTION_W'($urandom_range(int'(ACT_LONG_RD)));
    case ($urandom_range(9))
      0: addr = '0;
      1: addr = '1;
      default: addr = ADDR_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: wdata = '0;
      1: wdata = '1;
      default: wdata = $urandom;
    endcase
    if ($urandom_range(9) == 0) send_noise();
    run_transfer(act, addr, wdata, NOISE_PCT);
  endtask

  task automatic wait_drained();
    in_req.valid = 1'b0;
    while (scoreboard.expected_frames.size() != 0) @(negedge clk);
  endtask

  initial begin
    int goal;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.action = ACT_WORD_WR;
    in_req.address = '0;
    in_req.write_data = '0;
    in_req.rx_byte = '0;
    out_res.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // stray byte and unused action while idle
    send_item(ACT_RX_BYTE, '0, '0, 8'hFF);
    send_item(ACT_UNUSED_HI, '1, '1, 8'hFF);
    // word write at the top address, with a request arriving while busy
    send_item(ACT_WORD_WR, '1, '1, '0);
    send_item(ACT_LONG_RD, '0, '0, '0);
    repeat (10) send_item(ACT_RX_BYTE, '0, '0, 8'hFF);
    // word read at address zero, all-ones in the data slots
    send_item(ACT_WORD_RD, '0, '0, '0);
    for (int i = 0; i < 12; i++)
      send_item(ACT_RX_BYTE, '1, '1, (i % 6 == 5) ? 8'hFF : BYTE_W'($urandom));
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = scoreboard.effective_items + ITEMS_PER_PHASE;
      while (scoreboard.effective_items < goal) random_transfer();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    scoreboard.failures += scoreboard.expected_frames.size();
    if (scoreboard.failures == 0) begin
      $display("tb_spi_sram_word_access_sequencer: done, clean");
    end else begin
      $display("tb_spi_sram_word_access_sequencer: done, errors");
    end
    $finish;
  end

endmodule

/* spi_sram_word_access_sequencer.f */
src/sss_pkg.sv
src/sss_if.sv
src/sss_front.sv
src/sss_queue.sv
src/sss_back.sv
src/spi_sram_word_access_sequencer.sv
tb/tb_spi_sram_word_access_sequencer.sv
